// ===== design/lsi_pkg.sv =====
package lsi_pkg;

    localparam int PIX_W      = 10;
    localparam int HV_W       = 16;
    localparam int COEF_W     = 7;
    localparam int TAPS       = 8;
    localparam int LINES      = 7;
    localparam int MAX_HEIGHT = 64;
    localparam int ROW_W      = $clog2(MAX_HEIGHT + LINES);
    localparam int HSUM_W     = 20;
    localparam int VSUM_W     = 26;

    typedef logic [PIX_W-1:0]                 pix_t;
    typedef logic signed [HV_W-1:0]           hval_t;
    typedef logic signed [COEF_W-1:0]         coef_t;
    typedef logic signed [PIX_W+COEF_W:0]     hprod_t;
    typedef logic signed [HV_W+COEF_W-1:0]    vprod_t;
    typedef logic [LINES-1:0][HV_W-1:0]       col_word_t;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_FRAC_X       = 3'd0,
        CFG_FRAC_Y       = 3'd1,
        CFG_BIT_DEPTH    = 3'd2,
        CFG_BLOCK_WIDTH  = 3'd3,
        CFG_BLOCK_HEIGHT = 3'd4
    } cfg_idx_t;

    // 8-tap quarter-pel filters, one row per nonzero phase
    localparam coef_t FILT [3][TAPS] = '{
        '{-7'sd1, 7'sd4, -7'sd10, 7'sd57, 7'sd19, -7'sd7,  7'sd3, -7'sd1},
        '{-7'sd1, 7'sd4, -7'sd11, 7'sd40, 7'sd40, -7'sd11, 7'sd4, -7'sd1},
        '{-7'sd1, 7'sd3, -7'sd7,  7'sd19, 7'sd57, -7'sd10, 7'sd4, -7'sd1}
    };

    function automatic coef_t coef_of(input logic [1:0] frac, input logic [2:0] k);
        coef_t c;
        if (frac == 2'd0)
            c = '0;
        else
            c = FILT[frac - 2'd1][k];
        return c;
    endfunction

    // clip a signed value to 0 .. 2^bd-1
    function automatic pix_t clip_pix(input logic signed [VSUM_W-1:0] v,
                                      input logic [3:0] bd);
        logic signed [VSUM_W-1:0] mx;
        pix_t res;
        mx = (VSUM_W'(1) <<< bd) - VSUM_W'(1);
        if (v < 0)
            res = '0;
        else if (v > mx)
            res = mx[PIX_W-1:0];
        else
            res = v[PIX_W-1:0];
        return res;
    endfunction

endpackage

// ===== design/lsi_tap_cell.sv =====
module lsi_tap_cell
    import lsi_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   shift,
    input  pix_t   sample_in,
    input  coef_t  coef,
    output pix_t   sample_out,
    output hprod_t product
);

    pix_t   sample_reg;
    hprod_t product_reg;

    // one tap of the row window: hold a pixel, pass it left
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else if (shift)
        begin
            sample_reg <= sample_in;
        end
    end

    // weighted tap, taken with the window as it stands on arrival
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            product_reg <= $signed({1'b0, sample_reg}) * coef;
        end
    end

    assign sample_out = sample_reg;
    assign product    = product_reg;

endmodule

// ===== design/luma_subpel_interpolator_core.sv =====
// Quarter-pel luma interpolator for one prediction block. Reference pixels enter in raster
// order over a (width+7) x (height+7) window and one prediction pixel leaves for every window
// pixel whose 8x8 neighborhood is complete, with last_of_block set on the final one. The block
// takes one pixel per clock unless stalled; a result passes stages s1, s2, s3 and out. The
// horizontal filter is a chain of seven tap cells plus the incoming pixel; the vertical filter
// reads a column store of MAX_WIDTH words, each holding the seven previous horizontal values
// of a column, with one read and one write per clock. No clearing pass is needed after reset.
// Registers may be written only while the block is idle; a register write restarts the window.
module luma_subpel_interpolator_core
    import lsi_pkg::*;
#(
    parameter int MAX_WIDTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [6:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  pix_t       ref_pixel,
    output logic       out_valid,
    input  logic       out_stall,
    output pix_t       pred_pixel,
    output logic       last_of_block
);

    localparam int CW = $clog2(MAX_WIDTH + LINES);
    localparam int XW = $clog2(MAX_WIDTH);

    logic [1:0]     frac_x_reg, frac_y_reg;
    logic [3:0]     bit_depth_reg;
    logic [6:0]     block_width_reg, block_height_reg;
    logic [CW-1:0]  col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [3:0]     bd_eff;
    logic [CW-1:0]  bw_sat;
    logic [ROW_W-1:0] bh_sat;
    logic           accept, h_active, is_last;
    logic [XW-1:0]  x_in;

    logic ld1, ld2, ld3, ld_out;

    // stage registers
    logic       s1_valid_reg, s1_out_reg, s1_last_reg;
    logic [XW-1:0] s1_x_reg;
    pix_t       s1_center_reg;
    col_word_t  s1_word_reg;
    hprod_t     s1_tap7_reg;
    logic       s2_valid_reg, s2_last_reg;
    col_word_t  s2_word_reg;
    hval_t      s2_hv_reg;
    logic       s3_valid_reg, s3_last_reg;
    vprod_t     s3_prod_reg [TAPS];
    hval_t      s3_mid_reg;
    logic       out_valid_reg, out_last_reg;
    pix_t       out_pix_reg;

    col_word_t  colmem [MAX_WIDTH];

    pix_t       tap [TAPS];
    hprod_t     hprod [TAPS];
    logic signed [HSUM_W-1:0] hsum, hround;
    hval_t      hv;
    vprod_t     vprod [TAPS];
    logic signed [VSUM_W-1:0] vsum, vround;
    pix_t       vpix;
    logic [1:0] sh1;
    logic [3:0] sh2;

    // effective depth and block size
    always_comb
    begin
        if (bit_depth_reg < 4'd8)
            bd_eff = 4'd8;
        else if (bit_depth_reg > 4'd10)
            bd_eff = 4'd10;
        else
            bd_eff = bit_depth_reg;

        if (block_width_reg < 7'd4)
            bw_sat = CW'(4);
        else if (int'(block_width_reg) > MAX_WIDTH)
            bw_sat = CW'(MAX_WIDTH);
        else
            bw_sat = CW'(block_width_reg);

        if (block_height_reg < 7'd4)
            bh_sat = ROW_W'(4);
        else if (int'(block_height_reg) > MAX_HEIGHT)
            bh_sat = ROW_W'(MAX_HEIGHT);
        else
            bh_sat = ROW_W'(block_height_reg);
    end

    // elastic pipeline: a stage loads when empty or when its successor loads
    assign ld_out   = !out_valid_reg || !out_stall;
    assign ld3      = !s3_valid_reg || ld_out;
    assign ld2      = !s2_valid_reg || ld3;
    assign ld1      = !s1_valid_reg || ld2;
    assign in_stall = !ld1;
    assign accept   = in_valid && ld1;

    assign h_active = col_reg >= CW'(LINES);
    assign x_in     = XW'(col_reg - CW'(LINES));
    assign is_last  = (col_reg == bw_sat + CW'(LINES - 1)) &&
                      (row_reg == bh_sat + ROW_W'(LINES - 1));

    // window position of the next item
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_reg == bw_sat + CW'(LINES - 1))
            begin
                col_next = '0;
                if (row_reg == bh_sat + ROW_W'(LINES - 1))
                    row_next = '0;
                else
                    row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    // configuration registers and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_x_reg       <= 2'd0;
            frac_y_reg       <= 2'd0;
            bit_depth_reg    <= 4'd8;
            block_width_reg  <= 7'd8;
            block_height_reg <= 7'd8;
            col_reg          <= '0;
            row_reg          <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAC_X:
                begin
                    frac_x_reg <= cfg_data[1:0];
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                CFG_FRAC_Y:
                begin
                    frac_y_reg <= cfg_data[1:0];
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                CFG_BIT_DEPTH:
                begin
                    bit_depth_reg <= cfg_data[3:0];
                    col_reg       <= '0;
                    row_reg       <= '0;
                end
                CFG_BLOCK_WIDTH:
                begin
                    block_width_reg <= cfg_data;
                    col_reg         <= '0;
                    row_reg         <= '0;
                end
                CFG_BLOCK_HEIGHT:
                begin
                    block_height_reg <= cfg_data;
                    col_reg          <= '0;
                    row_reg          <= '0;
                end
                default:
                begin
                    col_reg <= col_next;
                    row_reg <= row_next;
                end
            endcase
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // row window: seven tap cells, newest pixel enters at the right
    assign tap[TAPS-1] = ref_pixel;
    for (genvar k = 0; k < TAPS - 1; k++)
    begin : g_tap
        lsi_tap_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (accept),
            .sample_in  (tap[k+1]),
            .coef       (coef_of(frac_x_reg, 3'(k))),
            .sample_out (tap[k]),
            .product    (hprod[k])
        );
    end
    assign hprod[TAPS-1] = s1_tap7_reg;

    // stage 1 control and column store read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (ld1)
            s1_valid_reg <= accept && h_active;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_tap7_reg   <= $signed({1'b0, ref_pixel}) * coef_of(frac_x_reg, 3'(TAPS - 1));
            s1_center_reg <= tap[3];
            s1_out_reg    <= row_reg >= ROW_W'(LINES);
            s1_last_reg   <= is_last;
            s1_x_reg      <= x_in;
        end
        if (accept && h_active)
            s1_word_reg <= colmem[x_in];
    end

    // horizontal sum, rounding and store format
    always_comb
    begin
        hsum = '0;
        for (int k = 0; k < TAPS; k++)
            hsum = hsum + HSUM_W'(hprod[k]);
        sh1 = 2'(bd_eff - 4'd8);
        if (frac_x_reg == 2'd0)
        begin
            hround = '0;
            hv     = hval_t'({6'd0, s1_center_reg});
        end
        else if (frac_y_reg == 2'd0)
        begin
            hround = (hsum + HSUM_W'(32)) >>> 6;
            hv     = hval_t'({6'd0, clip_pix(VSUM_W'(hround), bd_eff)});
        end
        else
        begin
            hround = (hsum + ((HSUM_W'(1) << sh1) >> 1)) >>> sh1;
            hv     = hround[HV_W-1:0];
        end
    end

    // column store write: age the column and append the new value
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && ld2)
            colmem[s1_x_reg] <= {hv, s1_word_reg[LINES-1:1]};
    end

    // stage 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (ld2)
            s2_valid_reg <= s1_valid_reg && s1_out_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ld2 && s1_valid_reg)
        begin
            s2_word_reg <= s1_word_reg;
            s2_hv_reg   <= hv;
            s2_last_reg <= s1_last_reg;
        end
    end

    // vertical taps
    always_comb
    begin
        for (int k = 0; k < LINES; k++)
            vprod[k] = $signed(s2_word_reg[k]) * coef_of(frac_y_reg, 3'(k));
        vprod[TAPS-1] = s2_hv_reg * coef_of(frac_y_reg, 3'(TAPS - 1));
    end

    // stage 3
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (ld3)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ld3 && s2_valid_reg)
        begin
            for (int k = 0; k < TAPS; k++)
                s3_prod_reg[k] <= vprod[k];
            s3_mid_reg  <= s2_word_reg[3];
            s3_last_reg <= s2_last_reg;
        end
    end

    // vertical sum, rounding and clip
    always_comb
    begin
        vsum = '0;
        for (int k = 0; k < TAPS; k++)
            vsum = vsum + VSUM_W'(s3_prod_reg[k]);
        sh2 = 4'd14 - (bd_eff - 4'd6);
        if (frac_y_reg == 2'd0)
        begin
            vround = VSUM_W'(s3_mid_reg);
            if (frac_x_reg == 2'd0)
                vpix = s3_mid_reg[PIX_W-1:0];
            else
                vpix = clip_pix(vround, bd_eff);
        end
        else if (frac_x_reg == 2'd0)
        begin
            vround = (vsum + VSUM_W'(32)) >>> 6;
            vpix   = clip_pix(vround, bd_eff);
        end
        else
        begin
            vround = (vsum + (VSUM_W'(1) << (sh2 - 4'd1))) >>> sh2;
            vpix   = clip_pix(vround, bd_eff);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ld_out)
            out_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ld_out && s3_valid_reg)
        begin
            out_pix_reg  <= vpix;
            out_last_reg <= s3_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pred_pixel    = out_pix_reg;
    assign last_of_block = out_last_reg;

endmodule

// ===== design/lsi_checker.sv =====
module lsi_checker
    import lsi_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_we,
    input logic [2:0] cfg_index,
    input logic [6:0] cfg_data,
    input logic       in_valid,
    input logic       in_stall,
    input pix_t       ref_pixel,
    input logic       out_valid,
    input logic       out_stall,
    input pix_t       pred_pixel,
    input logic       last_of_block
);

    logic [1:0] frac_x_reg, frac_y_reg;
    logic [3:0] bit_depth_reg;
    logic       filtered;

    // shadow of the registers that set the clip range
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_x_reg    <= 2'd0;
            frac_y_reg    <= 2'd0;
            bit_depth_reg <= 4'd8;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_FRAC_X)
                frac_x_reg <= cfg_data[1:0];
            if (cfg_index == CFG_FRAC_Y)
                frac_y_reg <= cfg_data[1:0];
            if (cfg_index == CFG_BIT_DEPTH)
                bit_depth_reg <= cfg_data[3:0];
        end
    end

    assign filtered = (frac_x_reg != 2'd0) || (frac_y_reg != 2'd0);

    // a stalled input item stays offered unchanged
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(ref_pixel))
        else $error("input item changed while stalled");

    // a stalled result stays offered unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pred_pixel) && $stable(last_of_block))
        else $error("result dropped or changed while stalled");

    // the input side only backs up behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with the output free");

    // filtered results respect the 8-bit clip
    a_clip8: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && filtered && bit_depth_reg <= 4'd8 |-> pred_pixel[9:8] == 2'b00)
        else $error("result above 8-bit range");

    // filtered results respect the 9-bit clip
    a_clip9: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && filtered && bit_depth_reg == 4'd9 |-> !pred_pixel[9])
        else $error("result above 9-bit range");

endmodule

bind luma_subpel_interpolator_core lsi_checker u_lsi_checker (.*);
